FILE: hw/rtl/bpp_pkg.sv
package bpp_pkg;

  localparam int unsigned FrameLength  = 5;
  localparam int unsigned CaptureDepth = 32;
  localparam int unsigned IdxW         = 6;
  // Positions kept in registers; the last frame byte is checked on the fly.
  localparam int unsigned StoredBytes  = FrameLength - 1;
  localparam int unsigned StoreIdxW    = $clog2(StoredBytes);

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [7:0] ByteStart = 8'h21;  // '!'
  localparam logic [7:0] ByteKind  = 8'h42;  // 'B'
  localparam logic [7:0] ByteZero  = 8'h30;  // '0'

  localparam logic [7:0] StepReset = 8'd30;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_LINK = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_VELOCITY_STEP = 1'b0,
    REG_TURN_STEP     = 1'b1
  } reg_idx_e;

  // Flag bit positions
  localparam int unsigned FlagFwd   = 0;
  localparam int unsigned FlagBack  = 1;
  localparam int unsigned FlagLeft  = 2;
  localparam int unsigned FlagRight = 3;

  // One queued result: the button flags after the item.
  typedef struct packed {
    logic [3:0] flags;
  } res_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
  } q_stat_t;

  // Queue head seen by the back.
  typedef struct packed {
    logic valid;
    res_t data;
  } q_head_t;

endpackage

FILE: hw/rtl/bpp_front.sv
module bpp_front
  import bpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic       link_up_i,
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output res_t       push_data_o
);

  logic            link_q, link_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [3:0]      flags_q, flags_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      frame_q [StoredBytes];

  logic            fire;
  logic [IdxW-1:0] idx_eff;
  logic            store;
  logic            keep_byte;
  logic            frame_ok;
  logic [3:0]      bit_sel;
  logic            pressed;

  assign in_ready_o = ~q_stat_i.full;
  assign fire       = in_valid_i & in_ready_o;

  always_comb begin
    idx_eff   = (rx_byte_i == ByteStart) ? '0 : idx_q;
    store     = idx_eff < IdxW'(CaptureDepth);
    keep_byte = idx_eff < IdxW'(StoredBytes);
    frame_ok  = store && (idx_eff == IdxW'(StoredBytes)) &&
                (frame_q[0] == ByteStart) && (frame_q[1] == ByteKind) &&
                (~sum_q == rx_byte_i);
    pressed   = frame_q[3] != ByteZero;
    case (frame_q[2])
      ByteZero + 8'd5: bit_sel = 4'b0001;
      ByteZero + 8'd6: bit_sel = 4'b0010;
      ByteZero + 8'd7: bit_sel = 4'b0100;
      ByteZero + 8'd8: bit_sel = 4'b1000;
      default:         bit_sel = 4'b0000;
    endcase

    link_d  = link_q;
    idx_d   = idx_q;
    flags_d = flags_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    if (fire) begin
      if (opcode_e'(opcode_i) == OP_LINK) begin
        link_d  = link_up_i;
        flags_d = '0;
        push_o  = 1'b1;
      end else if (link_q) begin
        idx_d = store ? idx_eff + IdxW'(1) : idx_eff;
        if (keep_byte) begin
          sum_d = (idx_eff == '0) ? rx_byte_i : sum_q + rx_byte_i;
        end
        if (frame_ok) begin
          flags_d = pressed ? (flags_q | bit_sel) : (flags_q & ~bit_sel);
          push_o  = 1'b1;
        end
      end
    end
    push_data_o.flags = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= 1'b0;
      idx_q   <= '0;
      flags_q <= '0;
      sum_q   <= '0;
    end else begin
      link_q  <= link_d;
      idx_q   <= idx_d;
      flags_q <= flags_d;
      sum_q   <= sum_d;
    end
  end

  // Frame store, only the first positions are kept.
  always_ff @(posedge clk_i) begin
    if (fire && opcode_e'(opcode_i) == OP_BYTE && link_q && keep_byte) begin
      frame_q[idx_eff[StoreIdxW-1:0]] <= rx_byte_i;
    end
  end

  // A byte-driven result needs the link up.
  a_frame_needs_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && opcode_e'(opcode_i) == OP_BYTE |-> link_q)
    else $error("frame result while link down");

endmodule

FILE: hw/rtl/bpp_fifo.sv
module bpp_fifo
  import bpp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  res_t    push_data_i,
  output q_stat_t stat_o,
  output q_head_t head_o,
  input  logic    pop_i
);

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = cnt_q == CntW'(FifoDepth);
  assign head_o.valid = cnt_q != '0;
  assign head_o.data  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_o.valid))
    else $error("queue underflow");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count mismatch");

endmodule

FILE: hw/rtl/bpp_back.sv
module bpp_back
  import bpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  input  q_head_t     head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  vel_cmd_o,
  output logic [8:0]  turn_cmd_o,
  output logic [3:0]  button_flags_o
);

  logic [7:0] vel_step_q, turn_step_q;
  logic       valid_q;
  logic [8:0] vel_q, vel_d;
  logic [8:0] turn_q, turn_d;
  logic [3:0] flags_q;
  logic [8:0] vs9, ts9;
  logic [3:0] f;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_step_q  <= StepReset;
      turn_step_q <= StepReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_VELOCITY_STEP: vel_step_q  <= cfg_data_i;
        REG_TURN_STEP:     turn_step_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  assign pop_o = head_i.valid & (~valid_q | out_ready_i);

  always_comb begin
    f      = head_i.data.flags;
    vs9    = {1'b0, vel_step_q};
    ts9    = {1'b0, turn_step_q};
    vel_d  = (f[FlagFwd]  ? vs9 : 9'd0) - (f[FlagBack]  ? vs9 : 9'd0);
    turn_d = (f[FlagLeft] ? ts9 : 9'd0) - (f[FlagRight] ? ts9 : 9'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      vel_q   <= vel_d;
      turn_q  <= turn_d;
      flags_q <= f;
    end
  end

  assign out_valid_o    = valid_q;
  assign vel_cmd_o      = vel_q;
  assign turn_cmd_o     = turn_q;
  assign button_flags_o = flags_q;

endmodule

FILE: hw/rtl/button_packet_parser_drive_core.sv
// Button packet parser and drive mixer.
// Input stream (s_axis): one item per received byte or link event. tuser is
//   the opcode (0 byte, 1 link change); tdata[7:0] the byte, tdata[8] the new
//   link state. A byte while the link is down is dropped without a result.
// Output stream (m_axis): one item per accepted "!B" frame and per link
//   event: velocity and turn commands (signed) and the four button flags.
// Config channel: cfg_addr_i 0 = velocity step, 1 = turn step, 8-bit data.
//   Always ready; write only while the block is idle.
// Throughput: one input item per cycle while the queue is not full. The
//   front parser updates its capture state and running checksum as each
//   item is accepted; the drive sums are formed in the back stage when a result leaves the queue.
// Result path: the queue is written at the edge that accepts the input item;
//   the output register is loaded from the queue head when it is empty or
//   m_axis takes its current result, so an m_axis stall holds results queued.
// Stall: a two-entry result queue sits between parser and output register.
//   While m_axis is stalled the parser keeps taking items until the queue
//   fills, then s_axis_tready_o drops.
// Reset: steps return to 30, flags clear, link down, capture index zero,
//   queue and output empty. No clearing pass is needed.
module button_packet_parser_drive_core
  import bpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] rx_byte, [8] link_up, rest zero
  input  logic        s_axis_tuser_i,   // [0] opcode
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [8:0] velocity command,
                                        // [17:9] turn command,
                                        // [21:18] button_flags, rest zero
);

  q_stat_t    q_stat;
  q_head_t    q_head;
  logic       push, pop;
  res_t       push_data;
  logic [8:0] vel, turn;
  logic [3:0] flags;

  // Front: capture, checksum, flag update
  bpp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i),
    .rx_byte_i   (s_axis_tdata_i[7:0]),
    .link_up_i   (s_axis_tdata_i[8]),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue of flag snapshots
  bpp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .stat_o      (q_stat),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  // Back: drive sums and output register, holds the step registers
  bpp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .head_i         (q_head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .vel_cmd_o      (vel),
    .turn_cmd_o     (turn),
    .button_flags_o (flags)
  );

  assign m_axis_tdata_o = {2'b00, flags, turn, vel};

endmodule
